// File: src/tec_pkg.sv
`timescale 1ns / 1ps

package tec_pkg;

   // Screen geometry and field widths.
   localparam int SCREEN_COLS = 40;
   localparam int SCREEN_ROWS = 8;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 3;
   localparam int CHAR_W      = 8;
   localparam int ACT_W       = 3;

   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CHAR_W-1:0] char_type;

   // Character codes that the parser recognises.
   localparam char_type CH_BEL     = 8'h07;
   localparam char_type CH_BS      = 8'h08;
   localparam char_type CH_LF      = 8'h0A;
   localparam char_type CH_CR      = 8'h0D;
   localparam char_type CH_SO      = 8'h0E;
   localparam char_type CH_SI      = 8'h0F;
   localparam char_type CH_ESC     = 8'h1B;
   localparam char_type CH_SPACE   = 8'h20;
   localparam char_type CH_LPAREN  = 8'h28;
   localparam char_type CH_RPAREN  = 8'h29;
   localparam char_type CH_ZERO    = 8'h30;
   localparam char_type CH_NINE    = 8'h39;
   localparam char_type CH_SEMI    = 8'h3B;
   localparam char_type CH_QUERY   = 8'h3F;
   localparam char_type CH_UP      = 8'h41;
   localparam char_type CH_DOWN    = 8'h42;
   localparam char_type CH_RIGHT   = 8'h43;
   localparam char_type CH_LEFT    = 8'h44;
   localparam char_type CH_GOTO    = 8'h48;
   localparam char_type CH_CLEAR   = 8'h4A;
   localparam char_type CH_ERASE   = 8'h4B;
   localparam char_type CH_CSI     = 8'h5B;
   localparam char_type CH_RESET   = 8'h63;
   localparam char_type CH_SGR     = 8'h6D;
   localparam char_type INVERSE_BIT = 8'h80;
   localparam char_type SGR_INVERSE = 8'd7;

   // Display commands carried in the result.
   typedef enum logic [ACT_W-1:0] {
      ACT_NONE  = 3'd0,
      ACT_DRAW  = 3'd1,
      ACT_CLEAR = 3'd2,
      ACT_ERASE = 3'd3,
      ACT_BELL  = 3'd4
   } action_type;

   // Escape parser phases.
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ESC  = 3'd1,
      PH_ARG1 = 3'd2,
      PH_ARG2 = 3'd3,
      PH_SKIP = 3'd4
   } phase_type;

   // Decoded operations handed from the front end to the back end.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_DRAW,
      OP_BACKSPACE,
      OP_CR,
      OP_LF,
      OP_BELL,
      OP_CLEAR_HOME,
      OP_HOME,
      OP_ERASE,
      OP_SET_INV,
      OP_UP,
      OP_DOWN,
      OP_LEFT,
      OP_RIGHT,
      OP_GOTO
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      char_type    arg_a;
      char_type    arg_b;
   } op_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      col_type          cell_col;
      row_type          cell_row;
      char_type         glyph;
      col_type          cursor_col;
      row_type          cursor_row;
   } rsp_type;

endpackage

// File: src/tec_req_if.sv
`timescale 1ns / 1ps

// Character input channel.
interface tec_req_if import tec_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// File: src/tec_rsp_if.sv
`timescale 1ns / 1ps

// Display command output channel.
interface tec_rsp_if import tec_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   col_type          cell_col;
   row_type          cell_row;
   char_type         glyph;
   col_type          cursor_col_out;
   row_type          cursor_row_out;

   modport source (output valid, output action, output cell_col, output cell_row,
                   output glyph, output cursor_col_out, output cursor_row_out,
                   input ready);
   modport sink   (input valid, input action, input cell_col, input cell_row,
                   input glyph, input cursor_col_out, input cursor_row_out,
                   output ready);
endinterface

// File: src/tec_front.sv
`timescale 1ns / 1ps

module tec_front import tec_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  char_type char_code,
   output op_type   op
);

   phase_type phase_ff, phase_in;
   char_type  first_ff, first_in;
   char_type  second_ff, second_in;
   logic      is_digit;

   // Decimal accumulate, wrapping modulo 256: acc * 10 + digit.
   function automatic char_type add_digit(input char_type acc, input char_type c);
      char_type digit;
      digit = c - CH_ZERO;
      return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + digit;
   endfunction

   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // Next parser state for an accepted item.
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (accept) begin
         if (char_code == CH_ESC) begin
            phase_in = PH_ESC;
         end else begin
            phase_in = PH_IDLE;
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_ESC: begin
                  first_in  = '0;
                  second_in = '0;
                  priority if (char_code == CH_CSI) begin
                     phase_in = PH_ARG1;
                  end else if (char_code == CH_LPAREN || char_code == CH_RPAREN) begin
                     phase_in = PH_SKIP;
                  end else begin
                     // Any other character ends the sequence.
                  end
               end
               PH_ARG1: begin
                  priority if (char_code == CH_SEMI) begin
                     phase_in = PH_ARG2;
                  end else if (char_code == CH_QUERY) begin
                     phase_in = PH_ARG1;
                  end else if (is_digit) begin
                     first_in = add_digit(first_ff, char_code);
                     phase_in = PH_ARG1;
                  end else begin
                     // A final character ends the sequence.
                  end
               end
               PH_ARG2: begin
                  if (is_digit) begin
                     second_in = add_digit(second_ff, char_code);
                     phase_in  = PH_ARG2;
                  end
               end
               PH_SKIP: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Classification of the current item into a back-end operation.
   always_comb begin
      op.code  = OP_NONE;
      op.arg_a = first_ff;
      op.arg_b = second_ff;
      if (char_code != CH_ESC) begin
         unique case (phase_ff)
            PH_IDLE: begin
               priority if (char_code == CH_CR) begin
                  op.code = OP_CR;
               end else if (char_code == CH_LF) begin
                  op.code = OP_LF;
               end else if (char_code == CH_BEL) begin
                  op.code = OP_BELL;
               end else if (char_code == CH_SI || char_code == CH_SO) begin
                  op.code = OP_NONE;
               end else if (char_code == CH_BS) begin
                  op.code = OP_BACKSPACE;
               end else begin
                  op.code  = OP_DRAW;
                  op.arg_a = char_code;
               end
            end
            PH_ESC: begin
               if (char_code == CH_RESET) begin
                  op.code = OP_CLEAR_HOME;
               end
            end
            PH_ARG1: begin
               priority if (char_code == CH_GOTO) begin
                  op.code = OP_HOME;
               end else if (char_code == CH_SGR) begin
                  // A single zero argument turns inverse off; others leave it.
                  if (first_ff == '0) begin
                     op.code  = OP_SET_INV;
                     op.arg_a = '0;
                  end
               end else if (char_code == CH_UP) begin
                  op.code = OP_UP;
               end else if (char_code == CH_DOWN) begin
                  op.code = OP_DOWN;
               end else if (char_code == CH_LEFT) begin
                  op.code = OP_LEFT;
               end else if (char_code == CH_RIGHT) begin
                  op.code = OP_RIGHT;
               end else if (char_code == CH_CLEAR) begin
                  op.code = OP_CLEAR_HOME;
               end else if (char_code == CH_ERASE) begin
                  op.code = OP_ERASE;
               end else begin
                  // Digits, separators and unknown finals give no command.
               end
            end
            PH_ARG2: begin
               priority if (char_code == CH_GOTO) begin
                  op.code = OP_GOTO;
               end else if (char_code == CH_SGR) begin
                  op.code  = OP_SET_INV;
                  op.arg_a = {{(CHAR_W-1){1'b0}}, second_ff == SGR_INVERSE};
               end else begin
                  // Digits and unknown finals give no command.
               end
            end
            PH_SKIP: begin
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: src/tec_fifo.sv
`timescale 1ns / 1ps

module tec_fifo import tec_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output logic   full,
   output logic   not_empty,
   output op_type head_op
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: src/tec_back.sv
`timescale 1ns / 1ps

module tec_back import tec_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op,
   output logic    pop,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp
);

   col_type   col_ff, col_in;
   row_type   row_ff, row_in;
   logic      inv_ff, inv_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   logic [CHAR_W:0] row_sum;
   logic [CHAR_W:0] col_sum;
   char_type        goto_row;
   char_type        goto_col;
   col_type         col_next;
   row_type         row_next;
   row_type         row_prev;

   // Take an operation whenever the output register is free or being emptied.
   assign pop       = op_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Cursor arithmetic shared by the operations.
   always_comb begin
      row_sum  = {1'b0, op.arg_a} + (CHAR_W+1)'(row_ff);
      col_sum  = {1'b0, op.arg_a} + (CHAR_W+1)'(col_ff);
      goto_row = (op.arg_a == '0) ? '0 : op.arg_a - 1'b1;
      goto_col = (op.arg_b == '0) ? '0 : op.arg_b - 1'b1;
      col_next = col_ff + 1'b1;
      row_next = (row_ff == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_ff + 1'b1;
      row_prev = (row_ff == '0) ? ROW_W'(SCREEN_ROWS - 1) : row_ff - 1'b1;
   end

   // Execute one operation.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      inv_in = inv_ff;
      rsp_in = '0;
      rsp_in.action = ACT_NONE;
      unique case (op.code)
         OP_NONE: begin
         end
         OP_DRAW: begin
            rsp_in.action   = ACT_DRAW;
            rsp_in.cell_col = col_ff;
            rsp_in.cell_row = row_ff;
            rsp_in.glyph    = op.arg_a | (inv_ff ? INVERSE_BIT : '0);
            if (col_next >= COL_W'(SCREEN_COLS)) begin
               col_in = '0;
               row_in = row_next;
            end else begin
               col_in = col_next;
            end
         end
         OP_BACKSPACE: begin
            rsp_in.action   = ACT_DRAW;
            rsp_in.cell_col = col_ff;
            rsp_in.cell_row = row_ff;
            rsp_in.glyph    = CH_SPACE;
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end else begin
               col_in = COL_W'(SCREEN_COLS - 1);
               row_in = row_prev;
            end
         end
         OP_CR: begin
            col_in = '0;
         end
         OP_LF: begin
            col_in = '0;
            row_in = row_next;
         end
         OP_BELL: begin
            rsp_in.action = ACT_BELL;
         end
         OP_CLEAR_HOME: begin
            rsp_in.action = ACT_CLEAR;
            col_in = '0;
            row_in = '0;
         end
         OP_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         OP_ERASE: begin
            rsp_in.action   = ACT_ERASE;
            rsp_in.cell_col = col_ff;
            rsp_in.cell_row = row_ff;
         end
         OP_SET_INV: begin
            inv_in = op.arg_a[0];
         end
         OP_UP: begin
            row_in = ({{(CHAR_W-ROW_W){1'b0}}, row_ff} < op.arg_a) ? '0 :
                     row_ff - op.arg_a[ROW_W-1:0];
         end
         OP_DOWN: begin
            row_in = (row_sum >= (CHAR_W+1)'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1) :
                     row_sum[ROW_W-1:0];
         end
         OP_LEFT: begin
            col_in = ({{(CHAR_W-COL_W){1'b0}}, col_ff} < op.arg_a) ? '0 :
                     col_ff - op.arg_a[COL_W-1:0];
         end
         OP_RIGHT: begin
            col_in = (col_sum >= (CHAR_W+1)'(SCREEN_COLS)) ? COL_W'(SCREEN_COLS - 1) :
                     col_sum[COL_W-1:0];
         end
         OP_GOTO: begin
            row_in = (goto_row >= CHAR_W'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1) :
                     goto_row[ROW_W-1:0];
            col_in = (goto_col >= CHAR_W'(SCREEN_COLS)) ? COL_W'(SCREEN_COLS - 1) :
                     goto_col[COL_W-1:0];
         end
         default: begin
         end
      endcase
      rsp_in.cursor_col = col_in;
      rsp_in.cursor_row = row_in;
   end

   // Cursor, attribute and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            col_ff <= col_in;
            row_ff <= row_in;
            inv_ff <= inv_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: src/terminal_escape_cursor_engine_unit.sv
`timescale 1ns / 1ps
// An accepted item goes into the decode queue and then, once the back end takes it,
// into the output register that drives the result.
// Throughput: one item per cycle while the output is not stalled.
// The decode queue holds FIFO_DEPTH items, so the input stalls only when it fills or in reset.
// Reset (synchronous, active high) homes the cursor, clears inverse, idles the parser
// and empties the queue and the output register.

module terminal_escape_cursor_engine_unit import tec_pkg::*; #(
   parameter int FIFO_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   tec_req_if.sink   req_bus,
   tec_rsp_if.source rsp_bus
);

   logic    req_accept;
   logic    fifo_full;
   logic    fifo_valid;
   logic    fifo_pop;
   op_type  front_op;
   op_type  head_op;
   rsp_type rsp;

   assign req_bus.ready = !fifo_full && !reset;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // Front end: escape parser and classification.
   tec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_code (req_bus.char_code),
      .op        (front_op)
   );

   // Queue between the parser and the cursor engine.
   tec_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_op   (front_op),
      .pop       (fifo_pop),
      .full      (fifo_full),
      .not_empty (fifo_valid),
      .head_op   (head_op)
   );

   // Back end: cursor, attribute and command generation.
   tec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (fifo_valid),
      .op        (head_op),
      .pop       (fifo_pop),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp       (rsp)
   );

   assign rsp_bus.action         = rsp.action;
   assign rsp_bus.cell_col       = rsp.cell_col;
   assign rsp_bus.cell_row       = rsp.cell_row;
   assign rsp_bus.glyph          = rsp.glyph;
   assign rsp_bus.cursor_col_out = rsp.cursor_col;
   assign rsp_bus.cursor_row_out = rsp.cursor_row;

   // An accepted item is waiting in the queue on the next cycle.
   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> fifo_valid)
      else $error("accepted item missing from the queue");

   // The back end never overwrites a result that is still stalled.
   a_no_pop_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !fifo_pop)
      else $error("queue popped while the output was stalled");

   // Every operation taken from the queue produces a result.
   a_pop_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      fifo_pop |=> rsp_bus.valid)
      else $error("operation taken without a result");

endmodule
